### rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers, removed when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define SPK_ASSERT(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion failed");
`define SPK_ASSERT_NEVER(label, clk, rst_n, cond) \
	`SPK_ASSERT(label, clk, rst_n, !(cond))
`else
`define SPK_ASSERT(label, clk, rst_n, prop)
`define SPK_ASSERT_NEVER(label, clk, rst_n, cond)
`endif

`endif

### rtl/core/spk64_pkg.sv
// ----------------------------------------------------------------------------
// spk64_pkg
// Types, constants and rotate helpers for the Speck64/128 encryptor.
// ----------------------------------------------------------------------------
`default_nettype none

package spk64_pkg;

	localparam int WORD_W    = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_KEY_WORD0 = 2'd0,
		CFG_KEY_WORD1 = 2'd1,
		CFG_KEY_WORD2 = 2'd2,
		CFG_KEY_WORD3 = 2'd3
	} spk64_cfg_idx_t;

	// round key and the three schedule words, l0 always next in use
	typedef struct packed {
		logic [WORD_W-1:0] rk;
		logic [WORD_W-1:0] l0;
		logic [WORD_W-1:0] l1;
		logic [WORD_W-1:0] l2;
	} spk64_key_t;

	typedef struct packed {
		logic [WORD_W-1:0] x;
		logic [WORD_W-1:0] y;
		spk64_key_t        key;
	} spk64_stage_t;

	typedef struct packed {
		logic [WORD_W-1:0] lo;
		logic [WORD_W-1:0] hi;
	} spk64_block_t;

	function automatic logic [WORD_W-1:0] ror8(input logic [WORD_W-1:0] v);
		ror8 = {v[7:0], v[WORD_W-1:8]};
	endfunction

	function automatic logic [WORD_W-1:0] rol3(input logic [WORD_W-1:0] v);
		rol3 = {v[WORD_W-4:0], v[WORD_W-1:WORD_W-3]};
	endfunction

endpackage

`default_nettype wire

### rtl/core/spk64_plain_if.sv
// ----------------------------------------------------------------------------
// spk64_plain_if
// Plaintext item channel: valid/ready with the two block words.
// ----------------------------------------------------------------------------
`default_nettype none

interface spk64_plain_if import spk64_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] plain_low;
	logic [WORD_W-1:0] plain_high;

	modport source (output valid, output plain_low, output plain_high, input ready);
	modport sink   (input valid, input plain_low, input plain_high, output ready);
endinterface

`default_nettype wire

### rtl/core/spk64_cipher_if.sv
// ----------------------------------------------------------------------------
// spk64_cipher_if
// Ciphertext item channel: valid/ready with the two block words.
// ----------------------------------------------------------------------------
`default_nettype none

interface spk64_cipher_if import spk64_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [WORD_W-1:0] cipher_low;
	logic [WORD_W-1:0] cipher_high;

	modport source (output valid, output cipher_low, output cipher_high, input ready);
	modport sink   (input valid, input cipher_low, input cipher_high, output ready);
endinterface

`default_nettype wire

### rtl/core/spk64_round.sv
// ----------------------------------------------------------------------------
// spk64_round
// One registered cipher round with its key schedule step.
// ----------------------------------------------------------------------------
`default_nettype none

module spk64_round import spk64_pkg::*; #(
	parameter int ROUND_IDX = 0
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         en,
	input  wire logic         in_valid,
	input  wire spk64_stage_t in_stage,
	output logic              out_valid,
	output spk64_stage_t      out_stage
);

	logic         valid_s;
	spk64_stage_t stage_s;
	spk64_stage_t nxt;
	logic [WORD_W-1:0] l_new;

	always_comb begin
		nxt.x   = (ror8(in_stage.x) + in_stage.y) ^ in_stage.key.rk;
		nxt.y   = rol3(in_stage.y) ^ nxt.x;
		l_new   = (in_stage.key.rk + ror8(in_stage.key.l0)) ^ WORD_W'(ROUND_IDX);
		nxt.key.rk = rol3(in_stage.key.rk) ^ l_new;
		nxt.key.l0 = in_stage.key.l1;
		nxt.key.l1 = in_stage.key.l2;
		nxt.key.l2 = l_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s <= 1'b0;
		end else if (en) begin
			valid_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			stage_s <= nxt;
		end
	end

	assign out_valid = valid_s;
	assign out_stage = stage_s;

endmodule

`default_nettype wire

### rtl/core/spk64_skid.sv
// ----------------------------------------------------------------------------
// spk64_skid
// Output register with a skid stage; upstream ready is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module spk64_skid import spk64_pkg::*; (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         in_valid,
	output logic              in_ready,
	input  wire spk64_block_t in_data,
	output logic              out_valid,
	input  wire logic         out_ready,
	output spk64_block_t      out_data
);

	logic         out_valid_q;
	logic         sk_valid_q;
	spk64_block_t out_data_q;
	spk64_block_t sk_data_q;
	logic         load;

	assign load = out_ready || !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			sk_valid_q  <= 1'b0;
		end else if (load) begin
			out_valid_q <= sk_valid_q || in_valid;
			sk_valid_q  <= 1'b0;
		end else if (in_valid && !sk_valid_q) begin
			sk_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q <= sk_valid_q ? sk_data_q : in_data;
		end else if (in_valid && !sk_valid_q) begin
			sk_data_q <= in_data;
		end
	end

	assign in_ready  = !sk_valid_q;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

### rtl/core/speck64_128_block_encrypt.sv
// ----------------------------------------------------------------------------
// speck64_128_block_encrypt
// Speck64/128 block encryptor, one round per pipeline stage.
// ----------------------------------------------------------------------------
// Usage:
//   Load the 128-bit key through cfg_we/cfg_index/cfg_data (index 0 is the
//   first round key, 1..3 the schedule words) while no item is in flight.
//   Plaintext items enter on the plain channel, ciphertext leaves on cipher.
//   Each item carries its own copy of the key schedule down the pipe.
// Pipeline:
//   ROUND_COUNT register stages, one round each, then an output register;
//   one item per cycle while the receiver does not stall.
// Reset:
//   arst_n clears all valid bits and the key words to zero.
// Stall:
//   A stalled receiver fills a one-item skid stage; the pipeline then holds
//   and plain.ready drops until the skid stage drains. Nothing is dropped.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module speck64_128_block_encrypt import spk64_pkg::*; #(
	parameter int ROUND_COUNT = 27
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [WORD_W-1:0]    cfg_data,
	spk64_plain_if.sink               plain,
	spk64_cipher_if.source            cipher
);

	spk64_key_t   key_q;
	logic         pipe_en;
	logic         pipe_valid [0:ROUND_COUNT];
	spk64_stage_t pipe_stage [0:ROUND_COUNT];
	spk64_block_t last_blk;
	spk64_block_t out_blk;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q <= '0;
		end else if (cfg_we) begin
			unique case (spk64_cfg_idx_t'(cfg_index))
				CFG_KEY_WORD0: key_q.rk <= cfg_data;
				CFG_KEY_WORD1: key_q.l0 <= cfg_data;
				CFG_KEY_WORD2: key_q.l1 <= cfg_data;
				CFG_KEY_WORD3: key_q.l2 <= cfg_data;
			endcase
		end
	end

	assign plain.ready      = pipe_en;
	assign pipe_valid[0]    = plain.valid;
	assign pipe_stage[0].x  = plain.plain_high;
	assign pipe_stage[0].y  = plain.plain_low;
	assign pipe_stage[0].key = key_q;

	for (genvar i = 0; i < ROUND_COUNT; i++) begin : g_round
		spk64_round #(
			.ROUND_IDX (i)
		) u_round (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (pipe_en),
			.in_valid  (pipe_valid[i]),
			.in_stage  (pipe_stage[i]),
			.out_valid (pipe_valid[i+1]),
			.out_stage (pipe_stage[i+1])
		);
	end

	assign last_blk.lo = pipe_stage[ROUND_COUNT].y;
	assign last_blk.hi = pipe_stage[ROUND_COUNT].x;

	spk64_skid u_skid (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pipe_valid[ROUND_COUNT]),
		.in_ready  (pipe_en),
		.in_data   (last_blk),
		.out_valid (cipher.valid),
		.out_ready (cipher.ready),
		.out_data  (out_blk)
	);

	assign cipher.cipher_low  = out_blk.lo;
	assign cipher.cipher_high = out_blk.hi;

	// an accepted item lands in the first stage
	`SPK_ASSERT(a_enter, clk, arst_n, plain.valid && plain.ready |=> pipe_valid[1])
	// a held pipeline keeps its last stage
	`SPK_ASSERT(a_hold, clk, arst_n, !pipe_en |=> pipe_valid[ROUND_COUNT] == $past(pipe_valid[ROUND_COUNT]))
	// skid stage only fills behind a waiting result
	`SPK_ASSERT_NEVER(a_skid, clk, arst_n, !pipe_en && !cipher.valid)

endmodule

`default_nettype wire
